// File: src/ocpu_pkg.sv
// Shared types and constants for the orbit camera pose update block.
`timescale 1ns / 1ps

package ocpu_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_YAW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PITCH    = 2'd2;

    // One queued pose job: updated angles (both as 0..3599 tenths), distance, target
    typedef struct packed {
        logic [11:0]        yaw;
        logic [11:0]        pitch;
        logic signed [15:0] orbit_dist;
        logic signed [31:0] tgt_x;
        logic signed [31:0] tgt_y;
        logic signed [31:0] tgt_z;
    } t_item;

endpackage

// File: src/ocpu_front.sv
// Front end: config registers, angle/distance state update, job push.
`timescale 1ns / 1ps

module ocpu_front import ocpu_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_look_held,
    input  logic                  i_has_cursor,
    input  logic signed [11:0]    i_cursor_dx,
    input  logic signed [11:0]    i_cursor_dy,
    input  logic                  i_has_scroll,
    input  logic signed [7:0]     i_scroll_dy,
    input  logic signed [31:0]    i_target_x,
    input  logic signed [31:0]    i_target_y,
    input  logic signed [31:0]    i_target_z,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_item                 o_item
);

    localparam logic [11:0]        ANG_FULL  = 12'd3600;
    localparam logic signed [10:0] CP_MAX    = 11'sd890;
    localparam logic signed [10:0] CP_MIN    = -11'sd890;
    localparam logic signed [13:0] UP_MAX    = 14'sd890;
    localparam logic signed [13:0] UP_MIN    = -14'sd890;
    localparam logic signed [16:0] D_MAX     = 17'sd32767;
    localparam logic signed [16:0] D_MIN     = -17'sd32768;

    logic [15:0]        r_cfg_dist, n_cfg_dist;
    logic [11:0]        r_cfg_yaw, n_cfg_yaw;
    logic [10:0]        r_cfg_pitch, n_cfg_pitch;
    logic               cfg_hit;
    logic [11:0]        r_yaw, ld_yaw, upd_yaw;
    logic signed [10:0] r_pitch, ld_pitch, upd_pitch;
    logic signed [15:0] r_dist, upd_dist;
    logic signed [14:0] dx_e, dx3, yaw_sum;
    logic [14:0]        wrap_v, wrap_r;
    logic signed [13:0] dy_e, dy3, p_sum;
    logic signed [10:0] p_clamp;
    logic signed [16:0] d_sum;
    logic signed [15:0] d_sat;
    logic signed [10:0] cfg_p;
    logic signed [12:0] p_ang;
    logic               accept;
    logic               look;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign look    = i_look_held && i_has_cursor;

    // Register write decode
    always_comb begin
        n_cfg_dist  = r_cfg_dist;
        n_cfg_yaw   = r_cfg_yaw;
        n_cfg_pitch = r_cfg_pitch;
        cfg_hit     = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_DISTANCE: begin
                    n_cfg_dist = i_cfg_data;
                    cfg_hit    = 1'b1;
                end
                CFG_START_YAW: begin
                    n_cfg_yaw = i_cfg_data[11:0];
                    cfg_hit   = 1'b1;
                end
                CFG_START_PITCH: begin
                    n_cfg_pitch = i_cfg_data[10:0];
                    cfg_hit     = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Normalize register values on load
    always_comb begin
        cfg_p  = $signed(n_cfg_pitch);
        ld_yaw = (n_cfg_yaw >= ANG_FULL) ? (n_cfg_yaw - ANG_FULL) : n_cfg_yaw;
        if (cfg_p > CP_MAX) begin
            ld_pitch = CP_MAX;
        end else if (cfg_p < CP_MIN) begin
            ld_pitch = CP_MIN;
        end else begin
            ld_pitch = cfg_p;
        end
    end

    // Yaw: add 3 tenths per pixel, wrap into 0..3599
    always_comb begin
        dx_e    = 15'(i_cursor_dx);
        dx3     = dx_e + (dx_e <<< 1);
        yaw_sum = $signed({3'b000, r_yaw}) + dx3;
        wrap_v  = unsigned'(yaw_sum + 15'sd7200);
        if (wrap_v >= 15'd14400) begin
            wrap_r = wrap_v - 15'd14400;
        end else if (wrap_v >= 15'd10800) begin
            wrap_r = wrap_v - 15'd10800;
        end else if (wrap_v >= 15'd7200) begin
            wrap_r = wrap_v - 15'd7200;
        end else if (wrap_v >= 15'd3600) begin
            wrap_r = wrap_v - 15'd3600;
        end else begin
            wrap_r = wrap_v;
        end
    end

    // Pitch: subtract 3 tenths per pixel, clamp to +-89 degrees
    always_comb begin
        dy_e  = 14'(i_cursor_dy);
        dy3   = dy_e + (dy_e <<< 1);
        p_sum = 14'(r_pitch) - dy3;
        if (p_sum > UP_MAX) begin
            p_clamp = CP_MAX;
        end else if (p_sum < UP_MIN) begin
            p_clamp = CP_MIN;
        end else begin
            p_clamp = p_sum[10:0];
        end
    end

    // Distance: subtract scroll, saturate
    always_comb begin
        d_sum = 17'(r_dist) - 17'(i_scroll_dy);
        if (d_sum > D_MAX) begin
            d_sat = 16'sh7fff;
        end else if (d_sum < D_MIN) begin
            d_sat = -16'sh8000;
        end else begin
            d_sat = d_sum[15:0];
        end
    end

    assign upd_yaw   = look ? wrap_r[11:0] : r_yaw;
    assign upd_pitch = look ? p_clamp : r_pitch;
    assign upd_dist  = i_has_scroll ? d_sat : r_dist;
    assign p_ang     = 13'(upd_pitch) + ((upd_pitch < 0) ? 13'sd3600 : 13'sd0);

    // Job word toward the back end
    always_comb begin
        o_push            = accept;
        o_item.yaw        = upd_yaw;
        o_item.pitch      = p_ang[11:0];
        o_item.orbit_dist = upd_dist;
        o_item.tgt_x      = i_target_x;
        o_item.tgt_y      = i_target_y;
        o_item.tgt_z      = i_target_z;
    end

    // Registers and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dist  <= 16'd10;
            r_cfg_yaw   <= 12'd0;
            r_cfg_pitch <= 11'd0;
            r_dist      <= 16'sd10;
            r_yaw       <= 12'd0;
            r_pitch     <= 11'sd0;
        end else if (cfg_hit) begin
            r_cfg_dist  <= n_cfg_dist;
            r_cfg_yaw   <= n_cfg_yaw;
            r_cfg_pitch <= n_cfg_pitch;
            r_dist      <= $signed(n_cfg_dist);
            r_yaw       <= ld_yaw;
            r_pitch     <= ld_pitch;
        end else if (accept) begin
            r_dist  <= upd_dist;
            r_yaw   <= upd_yaw;
            r_pitch <= upd_pitch;
        end
    end

endmodule

// File: src/ocpu_fifo.sv
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps

module ocpu_fifo import ocpu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: src/ocpu_back.sv
// Back end: sequenced sin/cos series on a shared multiplier, pose products, output register.
`timescale 1ns / 1ps

module ocpu_back import ocpu_pkg::*; #(
    parameter int TRIG_FRACTION_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_front_x,
    output logic signed [15:0] o_front_y,
    output logic signed [15:0] o_front_z,
    output logic               o_front_valid
);

    localparam int F    = TRIG_FRACTION_BITS;
    localparam int TW   = F + 2;
    localparam int DW   = 2 * F + 2;
    localparam int PW   = DW + 16;
    localparam int SH_T = 30 - F;
    localparam int SH16 = 2 * F - 16;
    localparam int SH14 = 2 * F - 14;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] HALF_T  = 31'(1) << (SH_T - 1);
    localparam logic [31:0] RAD     = 32'd1874033;
    localparam logic [3:0]  K_SIN_LAST = 4'd3;
    localparam logic [3:0]  K_COS_LAST = 4'd8;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_X    = 4'd1;
    localparam logic [3:0] S_X2   = 4'd2;
    localparam logic [3:0] S_M    = 4'd3;
    localparam logic [3:0] S_R    = 4'd4;
    localparam logic [3:0] S_C    = 4'd5;
    localparam logic [3:0] S_SF   = 4'd6;
    localparam logic [3:0] S_ST   = 4'd7;
    localparam logic [3:0] S_D0   = 4'd8;
    localparam logic [3:0] S_D1   = 4'd9;
    localparam logic [3:0] S_P    = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // Horner divisors: sin terms then cos terms
    function automatic logic [6:0] term_div(input logic [3:0] k);
        case (k)
            4'd0:    return 7'd72;
            4'd1:    return 7'd42;
            4'd2:    return 7'd20;
            4'd3:    return 7'd6;
            4'd4:    return 7'd90;
            4'd5:    return 7'd56;
            4'd6:    return 7'd30;
            4'd7:    return 7'd12;
            default: return 7'd2;
        endcase
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] term_recip(input logic [3:0] k);
        case (k)
            4'd0:    return 32'd59652323;
            4'd1:    return 32'd102261126;
            4'd2:    return 32'd214748364;
            4'd3:    return 32'd715827882;
            4'd4:    return 32'd47721858;
            4'd5:    return 32'd76695844;
            4'd6:    return 32'd143165576;
            4'd7:    return 32'd357913941;
            default: return 32'd2147483648;
        endcase
    endfunction

    // Shift right, rounding half away from zero
    function automatic logic signed [63:0] rnd_away(input logic signed [63:0] v, input int sh);
        logic        neg;
        logic [63:0] m;
        neg = v[63];
        m   = neg ? unsigned'(-v) : unsigned'(v);
        m   = (m + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    logic [3:0]           r_state;
    logic                 r_out_valid;
    t_item                r_item;
    logic                 r_sel;
    logic [3:0]           r_k;
    logic [1:0]           r_pi;
    logic [29:0]          r_x, r_x2, r_v, r_q0, r_sin;
    logic [30:0]          r_t, n_t;
    logic signed [TW-1:0] r_sy, r_cy, r_sp, r_cp;
    logic signed [DW-1:0] r_dir [3];
    logic signed [PW-1:0] r_prod [3];

    logic [11:0]          ang;
    logic [1:0]           quad;
    logic [11:0]          rem_a;
    logic [9:0]           rem;
    logic                 swap;
    logic [9:0]           fold;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic [37:0]          qd, rem_c;
    logic [29:0]          q_fix;
    logic [30:0]          sq_w, cq_w;
    logic signed [TW-1:0] sq, cq, s0, c0, s_fin, c_fin;
    logic signed [DW-1:0] dm_a, dm_b, dir_p, dir_y;
    logic signed [PW-1:0] pm;
    logic signed [31:0]   pos [3];
    logic signed [15:0]   fr [3];
    logic signed [31:0]   tgt [3];
    logic                 d_zero;
    logic                 load_out;

    // Angle fold into quadrant and first octant
    always_comb begin
        ang = r_sel ? r_item.pitch : r_item.yaw;
        if (ang >= 12'd2700) begin
            quad  = 2'd3;
            rem_a = ang - 12'd2700;
        end else if (ang >= 12'd1800) begin
            quad  = 2'd2;
            rem_a = ang - 12'd1800;
        end else if (ang >= 12'd900) begin
            quad  = 2'd1;
            rem_a = ang - 12'd900;
        end else begin
            quad  = 2'd0;
            rem_a = ang;
        end
        rem  = rem_a[9:0];
        swap = (rem > 10'd450);
        fold = swap ? (10'd900 - rem) : rem;
    end

    // Shared unsigned multiplier
    always_comb begin
        case (r_state)
            S_X: begin
                mul_a = {22'd0, fold};
                mul_b = RAD;
            end
            S_X2: begin
                mul_a = {2'b00, r_x};
                mul_b = {2'b00, r_x};
            end
            S_M: begin
                mul_a = {2'b00, r_x2};
                mul_b = {1'b0, r_t};
            end
            S_R: begin
                mul_a = {2'b00, r_v};
                mul_b = term_recip(r_k);
            end
            S_SF: begin
                mul_a = {2'b00, r_x};
                mul_b = {1'b0, r_t};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Quotient correction: estimate is exact or one low
    always_comb begin
        qd    = 38'(r_q0) * 38'(term_div(r_k));
        rem_c = 38'(r_v) - qd;
        q_fix = r_q0 + 30'(rem_c >= 38'(term_div(r_k)));
        n_t   = Q30_ONE - {1'b0, q_fix};
    end

    // Round to trig format and map back by octant and quadrant
    always_comb begin
        sq_w = ({1'b0, r_sin} + HALF_T) >> SH_T;
        cq_w = (r_t + HALF_T) >> SH_T;
        sq   = $signed({1'b0, sq_w[F:0]});
        cq   = $signed({1'b0, cq_w[F:0]});
        s0   = swap ? cq : sq;
        c0   = swap ? sq : cq;
        case (quad)
            2'd0: begin
                s_fin = s0;
                c_fin = c0;
            end
            2'd1: begin
                s_fin = c0;
                c_fin = -s0;
            end
            2'd2: begin
                s_fin = -s0;
                c_fin = -c0;
            end
            default: begin
                s_fin = -c0;
                c_fin = s0;
            end
        endcase
    end

    // Direction and offset products
    always_comb begin
        dm_a  = DW'(r_cp);
        dm_b  = (r_state == S_D0) ? DW'(r_sy) : DW'(r_cy);
        dir_p = dm_a * dm_b;
        dir_y = DW'(r_sp) <<< F;
        pm    = PW'(r_item.orbit_dist) * PW'(r_dir[r_pi]);
    end

    // Final rounding, target add and saturation
    always_comb begin
        tgt[0] = r_item.tgt_x;
        tgt[1] = r_item.tgt_y;
        tgt[2] = r_item.tgt_z;
        d_zero = (r_item.orbit_dist == 16'sd0);
        for (int i = 0; i < 3; i++) begin
            pos[i] = sat32(64'(tgt[i]) + rnd_away(64'(r_prod[i]), SH16));
            if (d_zero) begin
                fr[i] = 16'sd0;
            end else if (!r_item.orbit_dist[15]) begin
                fr[i] = 16'(-rnd_away(64'(r_dir[i]), SH14));
            end else begin
                fr[i] = 16'(rnd_away(64'(r_dir[i]), SH14));
            end
        end
    end

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_X;
                    end
                end
                S_X:  r_state <= S_X2;
                S_X2: r_state <= S_M;
                S_M:  r_state <= S_R;
                S_R:  r_state <= S_C;
                S_C: begin
                    if (r_k == K_SIN_LAST) begin
                        r_state <= S_SF;
                    end else if (r_k == K_COS_LAST) begin
                        r_state <= S_ST;
                    end else begin
                        r_state <= S_M;
                    end
                end
                S_SF: r_state <= S_M;
                S_ST: r_state <= r_sel ? S_D0 : S_X;
                S_D0: r_state <= S_D1;
                S_D1: r_state <= S_P;
                S_P: begin
                    if (r_pi == 2'd2) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    r_item <= i_item;
                    r_sel  <= 1'b0;
                end
            end
            S_X: begin
                r_x <= mul_p[29:0];
                r_t <= Q30_ONE;
                r_k <= 4'd0;
            end
            S_X2: r_x2 <= mul_p[59:30];
            S_M:  r_v  <= mul_p[59:30];
            S_R:  r_q0 <= mul_p[61:32];
            S_C: begin
                r_t <= n_t;
                r_k <= r_k + 4'd1;
            end
            S_SF: begin
                r_sin <= mul_p[59:30];
                r_t   <= Q30_ONE;
            end
            S_ST: begin
                if (r_sel) begin
                    r_sp <= s_fin;
                    r_cp <= c_fin;
                end else begin
                    r_sy  <= s_fin;
                    r_cy  <= c_fin;
                    r_sel <= 1'b1;
                end
            end
            S_D0: r_dir[0] <= dir_p;
            S_D1: begin
                r_dir[2] <= dir_p;
                r_dir[1] <= dir_y;
                r_pi     <= 2'd0;
            end
            S_P: begin
                r_prod[r_pi] <= pm;
                r_pi         <= r_pi + 2'd1;
            end
            default: begin
            end
        endcase
        if (load_out) begin
            o_pos_x       <= pos[0];
            o_pos_y       <= pos[1];
            o_pos_z       <= pos[2];
            o_front_x     <= fr[0];
            o_front_y     <= fr[1];
            o_front_z     <= fr[2];
            o_front_valid <= !d_zero;
        end
    end

endmodule

// File: src/orbit_camera_pose_update.sv
// Top level of the orbit camera pose update block.
`timescale 1ns / 1ps

//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    look, cursor, scroll, target
//  output    out        o_valid / i_stall    pos, front, front_valid
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
//  A pose runs from queue pop to output register through the pop state,
//  two sin/cos evaluations on the shared 32x32 multiplier, the direction
//  and product states and the output state. The front takes a word every
//  cycle while the two-entry queue has room. Reset is synchronous, active
//  low. A stalled result sits in the output register while the next pose
//  is already being computed.

module orbit_camera_pose_update import ocpu_pkg::*; #(
    parameter int TRIG_FRACTION_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_look_held,
    input  logic                  i_has_cursor,
    input  logic signed [11:0]    i_cursor_dx,
    input  logic signed [11:0]    i_cursor_dy,
    input  logic                  i_has_scroll,
    input  logic signed [7:0]     i_scroll_dy,
    input  logic signed [31:0]    i_target_x,
    input  logic signed [31:0]    i_target_y,
    input  logic signed [31:0]    i_target_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_pos_x,
    output logic signed [31:0]    o_pos_y,
    output logic signed [31:0]    o_pos_z,
    output logic signed [15:0]    o_front_x,
    output logic signed [15:0]    o_front_y,
    output logic signed [15:0]    o_front_z,
    output logic                  o_front_valid
);

    logic  push, full, pop, q_valid;
    t_item push_item, pop_item;

    ocpu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_look_held  (i_look_held),
        .i_has_cursor (i_has_cursor),
        .i_cursor_dx  (i_cursor_dx),
        .i_cursor_dy  (i_cursor_dy),
        .i_has_scroll (i_has_scroll),
        .i_scroll_dy  (i_scroll_dy),
        .i_target_x   (i_target_x),
        .i_target_y   (i_target_y),
        .i_target_z   (i_target_z),
        .i_q_full     (full),
        .o_push       (push),
        .o_item       (push_item)
    );

    ocpu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (pop_item)
    );

    ocpu_back #(
        .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_item        (pop_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_front_x     (o_front_x),
        .o_front_y     (o_front_y),
        .o_front_z     (o_front_z),
        .o_front_valid (o_front_valid)
    );

    // Zero distance gives a zero direction
    a_front_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_front_valid |-> o_front_x == 16'sd0 && o_front_y == 16'sd0
            && o_front_z == 16'sd0)
        else $error("front not zero with zero distance");

    // A real direction is never all zero
    a_front_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_front_valid |-> o_front_x != 16'sd0 || o_front_y != 16'sd0
            || o_front_z != 16'sd0)
        else $error("front all zero with nonzero distance");

    // No result straight out of reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule
